// File: rtl/sacl_pkg.sv
// shared constants and types of the set-associative cache lru unit
`default_nettype none

package sacl_pkg;

  localparam int unsigned DEF_MAX_SET_BITS = 6;
  localparam int unsigned DEF_MAX_WAYS     = 8;
  localparam int unsigned DEF_ADDR_WIDTH   = 64;

  localparam int unsigned RANK_W   = 3;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  // configuration register widths and limits
  localparam int unsigned SET_BITS_W   = 3;
  localparam int unsigned BLOCK_BITS_W = 6;
  localparam int unsigned WAYS_W       = 4;
  localparam int unsigned BLOCK_BITS_MAX = 32;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd1;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_reg_e;

  // what the lookup decided for one request
  typedef struct packed {
    logic hit;
    logic evict;
  } outcome_t;

endpackage

`default_nettype wire

// File: rtl/set_associative_cache_lru_unit.sv
// set-associative cache tag store with true lru replacement and running totals
//
//  channel   signals                                        direction
//  request   start, busy, access_address_i                  in, busy out
//  result    done_o, was_hit_o, was_evicted_o, *_total_o    out, one-cycle strobe
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i   in, ready out
//
// the set row of a request is read from the tag memory at the accepting
// edge, and the update cycle looks it up, writes the row back and registers
// the result, so done_o rises at the edge after the accepting one. busy
// holds off a new request during the update cycle, as the read-modify-write
// of the single memory port needs it; the write lands before the next
// read, so back-to-back requests to one set need no forwarding.
// reset clears the per-set valid flags, the totals and the configuration at
// once; there is no clearing pass. the result is not stalled by the receiver.
`default_nettype none

module set_associative_cache_lru_unit #(
  parameter int unsigned MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
  parameter int unsigned MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
  parameter int unsigned ADDR_WIDTH   = sacl_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [ADDR_WIDTH-1:0]             access_address_i,
  output logic                                   done_o,
  output logic                                   was_hit_o,
  output logic                                   was_evicted_o,
  output logic [sacl_pkg::CNT_W-1:0]             hit_total_o,
  output logic [sacl_pkg::CNT_W-1:0]             miss_total_o,
  output logic [sacl_pkg::CNT_W-1:0]             evict_total_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned RANK_W   = sacl_pkg::RANK_W;
  localparam int unsigned CNT_W    = sacl_pkg::CNT_W;
  localparam int unsigned TAG_W    = ADDR_WIDTH - 2;
  localparam int unsigned LINE_W   = 1 + TAG_W + RANK_W;
  localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
  localparam int unsigned SB_W     = sacl_pkg::SET_BITS_W;
  localparam int unsigned BB_W     = sacl_pkg::BLOCK_BITS_W;
  localparam int unsigned WW       = sacl_pkg::WAYS_W;
  localparam int unsigned SHAMT_W  = BB_W + 1;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  state_e state_q;

  logic [SB_W-1:0] set_bits_q;
  logic [BB_W-1:0] block_bits_q;
  logic [WW-1:0]   ways_q;

  logic [CNT_W-1:0] hit_cnt_q;
  logic [CNT_W-1:0] miss_cnt_q;
  logic [CNT_W-1:0] evict_cnt_q;
  logic             done_q;
  logic             was_hit_q;
  logic             was_evicted_q;

  logic [NUM_SETS-1:0]                     set_vld_q;
  logic [MAX_WAYS-1:0][LINE_W-1:0]         set_mem [NUM_SETS];
  logic [MAX_WAYS-1:0][LINE_W-1:0]         rd_row_q;
  logic                                    rd_vld_q;
  logic [MAX_SET_BITS-1:0]                 set_q;
  logic [TAG_W-1:0]                        tag_q;

  logic                                    accept;
  logic [ADDR_WIDTH-1:0]                   addr_blk;
  logic [ADDR_WIDTH-1:0]                   addr_tag;
  logic [SHAMT_W-1:0]                      tag_shamt;
  logic [MAX_SET_BITS-1:0]                 set_mask;
  logic [MAX_SET_BITS-1:0]                 set_idx;
  logic [MAX_WAYS-1:0][LINE_W-1:0]         new_row;
  sacl_pkg::outcome_t                      outcome;

  assign busy        = (state_q == ST_UPDATE);
  assign accept      = start && !busy;
  // settings hold still while a request is offered or in flight
  assign cfg_ready_o = !busy && !start;

  // set index and tag from the address
  assign addr_blk  = access_address_i >> block_bits_q;
  assign tag_shamt = SHAMT_W'(set_bits_q) + SHAMT_W'(block_bits_q);
  assign addr_tag  = access_address_i >> tag_shamt;
  assign set_mask  = ~({MAX_SET_BITS{1'b1}} << set_bits_q);
  assign set_idx   = addr_blk[MAX_SET_BITS-1:0] & set_mask;

  // tag memory: read at acceptance, written back in the update cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_row_q <= set_mem[set_idx];
      set_q    <= set_idx;
      tag_q    <= addr_tag[TAG_W-1:0];
    end
    if (state_q == ST_UPDATE) begin
      set_mem[set_q] <= new_row;
    end
  end

  sacl_lru_logic #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W)
  ) u_lru (
    .row_valid_i (rd_vld_q),
    .row_i       (rd_row_q),
    .tag_i       (tag_q),
    .ways_i      (ways_q),
    .row_o       (new_row),
    .outcome_o   (outcome)
  );

  // configuration, clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= sacl_pkg::SET_BITS_RST;
      block_bits_q <= sacl_pkg::BLOCK_BITS_RST;
      ways_q       <= sacl_pkg::WAYS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sacl_pkg::cfg_reg_e'(cfg_index_i))
        sacl_pkg::CFG_SET_BITS: begin
          if (cfg_data_i[SB_W-1:0] == '0) begin
            set_bits_q <= SB_W'(1);
          end else if (int'(cfg_data_i[SB_W-1:0]) > MAX_SET_BITS) begin
            set_bits_q <= SB_W'(MAX_SET_BITS);
          end else begin
            set_bits_q <= cfg_data_i[SB_W-1:0];
          end
        end
        sacl_pkg::CFG_BLOCK_BITS: begin
          if (cfg_data_i[BB_W-1:0] == '0) begin
            block_bits_q <= BB_W'(1);
          end else if (int'(cfg_data_i[BB_W-1:0]) > sacl_pkg::BLOCK_BITS_MAX) begin
            block_bits_q <= BB_W'(sacl_pkg::BLOCK_BITS_MAX);
          end else begin
            block_bits_q <= cfg_data_i[BB_W-1:0];
          end
        end
        sacl_pkg::CFG_WAYS: begin
          if (cfg_data_i[WW-1:0] == '0) begin
            ways_q <= WW'(1);
          end else if (int'(cfg_data_i[WW-1:0]) > MAX_WAYS) begin
            ways_q <= WW'(MAX_WAYS);
          end else begin
            ways_q <= cfg_data_i[WW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control, per-set valid flags, totals and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      set_vld_q     <= '0;
      rd_vld_q      <= 1'b0;
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      evict_cnt_q   <= '0;
      done_q        <= 1'b0;
      was_hit_q     <= 1'b0;
      was_evicted_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            rd_vld_q <= set_vld_q[set_idx];
            state_q  <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          set_vld_q[set_q] <= 1'b1;
          done_q           <= 1'b1;
          was_hit_q        <= outcome.hit;
          was_evicted_q    <= outcome.evict;
          if (outcome.hit) begin
            if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 1'b1;
          end else begin
            if (miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + 1'b1;
          end
          if (outcome.evict && (evict_cnt_q != '1)) begin
            evict_cnt_q <= evict_cnt_q + 1'b1;
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign was_hit_o     = was_hit_q;
  assign was_evicted_o = was_evicted_q;
  assign hit_total_o   = hit_cnt_q;
  assign miss_total_o  = miss_cnt_q;
  assign evict_total_o = evict_cnt_q;

  // a result only follows an update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_UPDATE))
    else $error("result strobe without an update cycle");

  // an accepted request always blocks the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted without entering the update cycle");

  // a hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(was_hit_o && was_evicted_o))
    else $error("result flagged as both hit and eviction");

  // every eviction is also a miss
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_total_o <= miss_total_o)
    else $error("eviction total exceeds miss total");

endmodule

`default_nettype wire

// File: rtl/sacl_lru_logic.sv
// lookup, victim choice and age update over one set row
`default_nettype none

module sacl_lru_logic #(
  parameter int unsigned MAX_WAYS = sacl_pkg::DEF_MAX_WAYS,
  parameter int unsigned TAG_W    = sacl_pkg::DEF_ADDR_WIDTH - 2
) (
  input  wire logic                                                  row_valid_i,
  input  wire logic [MAX_WAYS-1:0][TAG_W+sacl_pkg::RANK_W:0]        row_i,
  input  wire logic [TAG_W-1:0]                                      tag_i,
  input  wire logic [sacl_pkg::WAYS_W-1:0]                           ways_i,
  output logic      [MAX_WAYS-1:0][TAG_W+sacl_pkg::RANK_W:0]        row_o,
  output sacl_pkg::outcome_t                                         outcome_o
);

  localparam int unsigned RANK_W = sacl_pkg::RANK_W;
  localparam int unsigned LINE_W = 1 + TAG_W + RANK_W;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0]             in_use;
  logic [MAX_WAYS-1:0]             line_vld;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  line_tag;
  logic [MAX_WAYS-1:0][RANK_W-1:0] line_rank;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]    = (int'(ways_i) > w);
      line_vld[w]  = row_valid_i & row_i[w][LINE_W-1];
      line_tag[w]  = row_i[w][RANK_W +: TAG_W];
      line_rank[w] = row_i[w][RANK_W-1:0];
    end
  end

  always_comb begin
    logic              hit_found;
    logic              free_found;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  vic_way;
    logic [RANK_W-1:0] vic_rank;
    logic [WAY_W-1:0]  touch;
    logic [RANK_W:0]   limit;

    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    // walk downwards so the lowest way wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && line_vld[w] && (line_tag[w] == tag_i)) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (in_use[w] && !line_vld[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end

    // oldest way in use, ties to the lowest way
    vic_way  = '0;
    vic_rank = line_rank[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (line_rank[w] > vic_rank)) begin
        vic_way  = WAY_W'(w);
        vic_rank = line_rank[w];
      end
    end

    if (hit_found) begin
      touch = hit_way;
      limit = {1'b0, line_rank[hit_way]};
    end else if (free_found) begin
      touch = free_way;
      limit = {1'b0, sacl_pkg::RANK_MAX} + 1'b1;
    end else begin
      touch = vic_way;
      limit = {1'b0, vic_rank};
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      row_o[w] = {line_vld[w], line_tag[w], line_rank[w]};
      if (WAY_W'(w) == touch) begin
        row_o[w] = {1'b1, tag_i, {RANK_W{1'b0}}};
      end else if (in_use[w] && line_vld[w] && ({1'b0, line_rank[w]} < limit) &&
                   (line_rank[w] != sacl_pkg::RANK_MAX)) begin
        row_o[w][RANK_W-1:0] = line_rank[w] + 1'b1;
      end
    end

    outcome_o.hit   = hit_found;
    outcome_o.evict = !hit_found && !free_found;
  end

endmodule

`default_nettype wire

// File: bench/set_associative_cache_lru_unit_tb.sv
// self-checking bench for the cache tag store: directed table, then random phases
`timescale 1ns / 1ps

module set_associative_cache_lru_unit_tb;

  localparam int unsigned NUM_WAYS   = sacl_pkg::DEF_MAX_WAYS;
  localparam int unsigned STORE_SIZE = (1 << sacl_pkg::DEF_MAX_SET_BITS) * sacl_pkg::DEF_MAX_WAYS;
  localparam int unsigned NUM_PHASES = 12;
  localparam int unsigned PHASE_LEN  = 153;
  localparam int unsigned CNT_W      = sacl_pkg::CNT_W;
  localparam int unsigned CFG_IDX_W  = sacl_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = sacl_pkg::CFG_DATA_W;
  localparam int unsigned RANK_W     = sacl_pkg::RANK_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef enum logic {ROW_ACCESS, ROW_WRITE} row_kind_e;

  typedef struct packed {
    logic             hit;
    logic             evict;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evicts;
  } lookup_res_t;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [63:0]            addr;
    logic                   typed;
    lookup_res_t            want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy;
  logic [63:0]           addr_i;
  logic                  done_o;
  logic                  was_hit_o;
  logic                  was_evicted_o;
  logic [CNT_W-1:0]      hit_total_o;
  logic [CNT_W-1:0]      miss_total_o;
  logic [CNT_W-1:0]      evict_total_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // shadow copy of the tag store and its settings
  logic                  shadow_valid [STORE_SIZE];
  logic [63:0]           shadow_tag   [STORE_SIZE];
  logic [RANK_W-1:0]     shadow_rank  [STORE_SIZE];
  logic [CNT_W-1:0]      shadow_hits, shadow_misses, shadow_evicts;
  int unsigned           shadow_sb, shadow_bb, shadow_ways;

  lookup_res_t           pending_lookups [$];
  dir_row_t              dir_tab [$];
  int unsigned           err_cnt = 0;

  set_associative_cache_lru_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start_i),
    .busy             (busy),
    .access_address_i (addr_i),
    .done_o           (done_o),
    .was_hit_o        (was_hit_o),
    .was_evicted_o    (was_evicted_o),
    .hit_total_o      (hit_total_o),
    .miss_total_o     (miss_total_o),
    .evict_total_o    (evict_total_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("set_associative_cache_lru_unit_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int unsigned clamp_val(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic dir_row_t row_access(logic [63:0] a);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ACCESS;
    r.addr = a;
    return r;
  endfunction

  function automatic dir_row_t row_checked(logic [63:0] a, logic h, logic e,
                                           logic [CNT_W-1:0] nh, logic [CNT_W-1:0] nm,
                                           logic [CNT_W-1:0] ne);
    dir_row_t r;
    r = row_access(a);
    r.typed = 1'b1;
    r.want  = '{hit: h, evict: e, hits: nh, misses: nm, evicts: ne};
    return r;
  endfunction

  function automatic dir_row_t row_write(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx  = i;
    r.val  = v;
    return r;
  endfunction

  // ages every valid way in use other than skip whose rank is below limit
  task automatic age_ways(input int unsigned base, input int unsigned skip,
                          input int unsigned limit);
    int unsigned w;
    for (w = 0; w < shadow_ways; w++) begin
      if (w != skip && shadow_valid[base+w] &&
          shadow_rank[base+w] < limit && shadow_rank[base+w] != sacl_pkg::RANK_MAX)
        shadow_rank[base+w] = shadow_rank[base+w] + 1'b1;
    end
  endtask

  // looks one address up in the shadow store and updates it
  task automatic lookup_predict(input logic [63:0] a, output lookup_res_t res);
    logic [63:0]  tag_v;
    int unsigned  set_v, base, w, victim, best;
    int           hit_way, free_way;
    tag_v    = a >> (shadow_sb + shadow_bb);
    set_v    = int'((a >> shadow_bb) & ((64'd1 << shadow_sb) - 1));
    base     = set_v * NUM_WAYS;
    hit_way  = -1;
    free_way = -1;
    res      = '0;
    for (w = 0; w < shadow_ways; w++) begin
      if (shadow_valid[base+w]) begin
        if (hit_way < 0 && shadow_tag[base+w] == tag_v) hit_way = int'(w);
      end else if (free_way < 0) begin
        free_way = int'(w);
      end
    end
    if (hit_way >= 0) begin
      res.hit = 1'b1;
      shadow_hits = sat_bump(shadow_hits);
      age_ways(base, hit_way, shadow_rank[base+hit_way]);
      shadow_rank[base+hit_way] = '0;
    end else begin
      shadow_misses = sat_bump(shadow_misses);
      if (free_way >= 0) begin
        age_ways(base, free_way, sacl_pkg::RANK_MAX + 1);
        shadow_valid[base+free_way] = 1'b1;
        shadow_tag[base+free_way]   = tag_v;
        shadow_rank[base+free_way]  = '0;
      end else begin
        victim = 0;
        best   = shadow_rank[base];
        for (w = 1; w < shadow_ways; w++) begin
          if (shadow_rank[base+w] > best) begin
            best   = shadow_rank[base+w];
            victim = w;
          end
        end
        res.evict = 1'b1;
        shadow_evicts = sat_bump(shadow_evicts);
        age_ways(base, victim, shadow_rank[base+victim]);
        shadow_tag[base+victim]  = tag_v;
        shadow_rank[base+victim] = '0;
      end
    end
    res.hits   = shadow_hits;
    res.misses = shadow_misses;
    res.evicts = shadow_evicts;
  endtask

  // start stays high after acceptance so the next request can follow at once
  task automatic issue_access(input logic [63:0] a, input logic use_typed,
                              input lookup_res_t typed);
    lookup_res_t res;
    start_i <= 1'b1;
    addr_i  <= a;
    do @(posedge clk_i); while (busy !== 1'b0);
    lookup_predict(a, res);
    pending_lookups.push_back(use_typed ? typed : res);
  endtask

  task automatic pause_for(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    start_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      sacl_pkg::CFG_SET_BITS:
        shadow_sb   = clamp_val(v[2:0], 1, sacl_pkg::DEF_MAX_SET_BITS);
      sacl_pkg::CFG_BLOCK_BITS:
        shadow_bb   = clamp_val(v[5:0], 1, sacl_pkg::BLOCK_BITS_MAX);
      sacl_pkg::CFG_WAYS:
        shadow_ways = clamp_val(v[3:0], 1, sacl_pkg::DEF_MAX_WAYS);
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : check_results
    lookup_res_t want;
    if (done_o === 1'b1) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_lookups.pop_front();
        if (was_hit_o !== want.hit)
          report_mismatch($sformatf("was_hit %b, want %b", was_hit_o, want.hit));
        if (was_evicted_o !== want.evict)
          report_mismatch($sformatf("was_evicted %b, want %b", was_evicted_o, want.evict));
        if (hit_total_o !== want.hits)
          report_mismatch($sformatf("hit_total %0d, want %0d", hit_total_o, want.hits));
        if (miss_total_o !== want.misses)
          report_mismatch($sformatf("miss_total %0d, want %0d", miss_total_o, want.misses));
        if (evict_total_o !== want.evicts)
          report_mismatch($sformatf("evict_total %0d, want %0d", evict_total_o, want.evicts));
      end
    end
  end

  initial begin
    int unsigned           p, n, k, pool_n, s;
    logic [63:0]           tag_pool [16];
    logic [63:0]           a, off;
    logic                  idle_on;
    logic [CFG_DATA_W-1:0] cfg_v [3];

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    addr_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    for (k = 0; k < STORE_SIZE; k++) begin
      shadow_valid[k] = 1'b0;
      shadow_tag[k]   = '0;
      shadow_rank[k]  = '0;
    end
    shadow_hits   = '0;
    shadow_misses = '0;
    shadow_evicts = '0;
    shadow_sb     = sacl_pkg::SET_BITS_RST;
    shadow_bb     = sacl_pkg::BLOCK_BITS_RST;
    shadow_ways   = sacl_pkg::WAYS_RST;

    // reset settings: one way, two sets, 16-byte blocks
    dir_tab.push_back(row_checked(64'h0, 1'b0, 1'b0, 0, 1, 0));
    dir_tab.push_back(row_checked(64'hF, 1'b1, 1'b0, 1, 1, 0));
    dir_tab.push_back(row_checked('1, 1'b0, 1'b0, 1, 2, 0));
    dir_tab.push_back(row_checked(64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 1'b0, 2, 2, 0));
    dir_tab.push_back(row_checked(64'h20, 1'b0, 1'b1, 2, 3, 1));
    dir_tab.push_back(row_checked(64'h0, 1'b0, 1'b1, 2, 4, 2));
    // out-of-range values clamp; the spare index is ignored
    dir_tab.push_back(row_write(sacl_pkg::CFG_SET_BITS, 8'h00));
    dir_tab.push_back(row_write(sacl_pkg::CFG_BLOCK_BITS, 8'hC0));
    dir_tab.push_back(row_write(sacl_pkg::CFG_WAYS, 8'hFF));
    dir_tab.push_back(row_write(CFG_SPARE_IDX, 8'hA5));
    // fill all eight ways of set zero, then two evictions
    for (k = 1; k <= 9; k++) dir_tab.push_back(row_access(64'(k) << 2));
    // shrink to one way so that ways zero and one end up with the same tag
    dir_tab.push_back(row_write(sacl_pkg::CFG_WAYS, 8'h01));
    dir_tab.push_back(row_access(64'h24));
    dir_tab.push_back(row_write(sacl_pkg::CFG_WAYS, 8'h08));
    dir_tab.push_back(row_access(64'h24));
    dir_tab.push_back(row_write(sacl_pkg::CFG_SET_BITS, 8'hFF));
    dir_tab.push_back(row_write(sacl_pkg::CFG_BLOCK_BITS, 8'hFF));
    dir_tab.push_back(row_write(sacl_pkg::CFG_WAYS, 8'hF0));
    dir_tab.push_back(row_access('1));
    dir_tab.push_back(row_access(64'h0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        wait_all_results();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        issue_access(dir_tab[i].addr, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: cfg_v = '{8'h01, 8'h01, 8'h01};
        1: cfg_v = '{8'h06, 8'h20, 8'h08};
        2: cfg_v = '{8'h07, 8'h3F, 8'h0F};
        3: cfg_v = '{8'h01, 8'h20, 8'h08};
        default: begin
          cfg_v[0] = 8'($urandom_range(0, 255));
          cfg_v[1] = 8'($urandom_range(0, 255));
          cfg_v[2] = 8'($urandom_range(0, 255));
        end
      endcase
      wait_all_results();
      write_reg(sacl_pkg::CFG_SET_BITS, cfg_v[0]);
      write_reg(sacl_pkg::CFG_BLOCK_BITS, cfg_v[1]);
      write_reg(sacl_pkg::CFG_WAYS, cfg_v[2]);
      if (p >= 4 && $urandom_range(0, 2) == 0)
        write_reg(CFG_SPARE_IDX, 8'($urandom_range(0, 255)));

      // a small pool of tags per phase gives a mix of hits, fills and evictions
      pool_n = shadow_ways + $urandom_range(0, 3);
      for (k = 0; k < pool_n; k++) tag_pool[k] = {$urandom, $urandom};
      idle_on = (p != 4);

      for (n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          a = {$urandom, $urandom};
        end else begin
          k   = $urandom_range(0, pool_n - 1);
          s   = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 1) : $urandom;
          s   = s & ((1 << shadow_sb) - 1);
          off = {$urandom, $urandom} & ((64'd1 << shadow_bb) - 1);
          a   = (tag_pool[k] << (shadow_sb + shadow_bb)) | (64'(s) << shadow_bb) | off;
        end
        issue_access(a, 1'b0, '0);
        if (p == 5 && n == PHASE_LEN / 2)
          wait_all_results();
        else if (idle_on && $urandom_range(0, 99) < 20)
          pause_for($urandom_range(1, 4));
      end
    end

    wait_all_results();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0)
      $display("set_associative_cache_lru_unit_tb passed");
    else
      $display("set_associative_cache_lru_unit_tb failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/sacl_pkg.sv
rtl/sacl_lru_logic.sv
rtl/set_associative_cache_lru_unit.sv
bench/set_associative_cache_lru_unit_tb.sv
